@@ hw/rtl/phw_pkg.sv @@
package phw_pkg;

  localparam int PHW_QUEUE_DEPTH = 2;

  localparam int PAYLOAD_LEN_W = 16;
  localparam int TS_W          = 33;
  localparam int BYTE_W        = 8;
  localparam int SID_EXT_W     = 7;
  localparam int HDR_LEN_W     = 5;
  localparam int CFG_INDEX_W   = 3;

  // header lengths in bytes
  localparam logic [HDR_LEN_W-1:0] SHORT_HDR_LEN = 5'd6;
  localparam logic [HDR_LEN_W-1:0] FLAG_BYTES    = 5'd3;
  localparam logic [HDR_LEN_W-1:0] TS_BYTES      = 5'd5;
  localparam logic [HDR_LEN_W-1:0] TS2_BYTES     = 5'd10;
  localparam logic [HDR_LEN_W-1:0] EXT_BYTES     = 5'd3;
  localparam logic [HDR_LEN_W-1:0] FIXED_HDR_LEN = 5'd9;

  // flag byte bits
  localparam logic [7:0] FLAG1_BASE     = 8'h81;
  localparam logic [7:0] FLAG1_ALIGN    = 8'h04;
  localparam logic [7:0] FLAG2_PTS_DTS  = 8'hC0;
  localparam logic [7:0] FLAG2_PTS_ONLY = 8'h80;
  localparam logic [7:0] FLAG2_EXT      = 8'h01;

  // extension bytes
  localparam logic [7:0] EXT_BYTE0 = 8'h0F;
  localparam logic [7:0] EXT_BYTE1 = 8'h81;
  localparam logic [7:0] EXT_MARK  = 8'h80;

  // timestamp prefix codes
  localparam logic [3:0] TS_CODE_PTS_ONLY = 4'h2;
  localparam logic [3:0] TS_CODE_PTS      = 4'h3;
  localparam logic [3:0] TS_CODE_DTS      = 4'h1;

  // reset values of the config registers
  localparam logic [7:0]           RST_STREAM_ID     = 8'd224;
  localparam logic [SID_EXT_W-1:0] RST_STREAM_ID_EXT = 7'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STREAM_ID     = 3'd0,
    REG_STREAM_ID_EXT = 3'd1,
    REG_FULL_HEADER   = 3'd2,
    REG_DATA_ALIGN    = 3'd3,
    REG_EXT_SID_ON    = 3'd4
  } phw_reg_t;

  // one header job, classified by the front end
  typedef struct packed {
    logic [BYTE_W-1:0]        sid;
    logic [PAYLOAD_LEN_W-1:0] pkt_len;
    logic [BYTE_W-1:0]        flag1;
    logic [BYTE_W-1:0]        flag2;
    logic [HDR_LEN_W-1:0]     hdr_len;
    logic                     ts_both;
    logic                     ext_on;
    logic [SID_EXT_W-1:0]     sid_ext;
    logic [TS_W-1:0]          pts;
    logic [TS_W-1:0]          dts;
  } phw_desc_t;

  function automatic logic [BYTE_W-1:0] ts_byte(input logic [3:0] code,
                                                input logic [TS_W-1:0] ts,
                                                input logic [2:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = {code, ts[32:30], 1'b1};
      3'd1:    b = ts[29:22];
      3'd2:    b = {ts[21:15], 1'b1};
      3'd3:    b = ts[14:7];
      3'd4:    b = {ts[6:0], 1'b1};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/phw_req_if.sv @@
interface phw_req_if import phw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PAYLOAD_LEN_W-1:0] payload_length;
  logic                     pts_present;
  logic [TS_W-1:0]          pts_value;
  logic                     dts_present;
  logic [TS_W-1:0]          dts_value;

  modport source (output valid, payload_length, pts_present, pts_value,
                  dts_present, dts_value, input ready);
  modport sink (input valid, payload_length, pts_present, pts_value,
                dts_present, dts_value, output ready);
endinterface

@@ hw/rtl/phw_hdr_if.sv @@
interface phw_hdr_if import phw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  logic              last_byte;

  modport source (output valid, header_byte, last_byte, input ready);
  modport sink (input valid, header_byte, last_byte, output ready);
endinterface

@@ hw/rtl/phw_queue.sv @@
module phw_queue import phw_pkg::*; #(
  parameter int Depth = PHW_QUEUE_DEPTH,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  phw_desc_t       push_data,
  input  logic            pop,
  output phw_desc_t       head_data,
  output logic            head_valid,
  output logic            full,
  output logic [CntW-1:0] count
);

  phw_desc_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_valid = (count != '0);
  assign full       = (count == CntW'(Depth));
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/phw_front.sv @@
module phw_front import phw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  phw_req_if.sink                req,
  input  logic                   q_full,
  output logic                   push,
  output phw_desc_t              push_data
);

  logic [BYTE_W-1:0]    sid;
  logic [SID_EXT_W-1:0] sid_ext;
  logic                 full_header;
  logic                 data_align;
  logic                 ext_sid_on;

  logic                 both;
  logic                 pts_only;
  logic                 ext;
  logic [HDR_LEN_W-1:0] ts_len;
  logic [HDR_LEN_W-1:0] hdr_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      sid         <= RST_STREAM_ID;
      sid_ext     <= RST_STREAM_ID_EXT;
      full_header <= 1'b1;
      data_align  <= 1'b0;
      ext_sid_on  <= 1'b0;
    end else if (cfg_we) begin
      case (phw_reg_t'(cfg_index))
        REG_STREAM_ID:     sid         <= cfg_data;
        REG_STREAM_ID_EXT: sid_ext     <= cfg_data[SID_EXT_W-1:0];
        REG_FULL_HEADER:   full_header <= cfg_data[0];
        REG_DATA_ALIGN:    data_align  <= cfg_data[0];
        REG_EXT_SID_ON:    ext_sid_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // a DTS without a PTS is dropped; short headers carry no options
  assign both     = full_header && req.pts_present && req.dts_present;
  assign pts_only = full_header && req.pts_present && !req.dts_present;
  assign ext      = full_header && ext_sid_on;

  always_comb begin
    ts_len = '0;
    if (both) begin
      ts_len = TS2_BYTES;
    end else if (pts_only) begin
      ts_len = TS_BYTES;
    end
    hdr_len = SHORT_HDR_LEN;
    if (full_header) begin
      hdr_len = SHORT_HDR_LEN + FLAG_BYTES + ts_len + (ext ? EXT_BYTES : '0);
    end
  end

  always_comb begin
    push_data         = '0;
    push_data.sid     = sid;
    push_data.pkt_len = PAYLOAD_LEN_W'(hdr_len - SHORT_HDR_LEN) + req.payload_length;
    push_data.flag1   = FLAG1_BASE | (data_align ? FLAG1_ALIGN : '0);
    push_data.flag2   = (both ? FLAG2_PTS_DTS : '0) | (pts_only ? FLAG2_PTS_ONLY : '0)
                        | (ext ? FLAG2_EXT : '0);
    push_data.hdr_len = hdr_len;
    push_data.ts_both = both;
    push_data.ext_on  = ext;
    push_data.sid_ext = sid_ext;
    push_data.pts     = req.pts_value;
    push_data.dts     = req.dts_value;
  end

endmodule

@@ hw/rtl/phw_back.sv @@
module phw_back import phw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  phw_desc_t head_data,
  output logic      pop,
  phw_hdr_if.source hdr
);

  localparam logic [HDR_LEN_W-1:0] POS_PREFIX2 = 5'd2;
  localparam logic [HDR_LEN_W-1:0] POS_SID     = 5'd3;
  localparam logic [HDR_LEN_W-1:0] POS_LEN_HI  = 5'd4;
  localparam logic [HDR_LEN_W-1:0] POS_LEN_LO  = 5'd5;
  localparam logic [HDR_LEN_W-1:0] POS_FLAG1   = 5'd6;
  localparam logic [HDR_LEN_W-1:0] POS_FLAG2   = 5'd7;
  localparam logic [HDR_LEN_W-1:0] POS_HDLEN   = 5'd8;
  localparam logic [HDR_LEN_W-1:0] POS_TS1     = 5'd9;
  localparam logic [HDR_LEN_W-1:0] POS_TS2     = 5'd14;

  logic [HDR_LEN_W-1:0] idx;
  logic                 hdr_valid_r;
  logic [BYTE_W-1:0]    hdr_byte_r;
  logic                 hdr_last_r;

  logic                 advance;
  logic                 is_last;
  logic [BYTE_W-1:0]    cur_byte;
  logic [HDR_LEN_W-1:0] ext_start;
  logic [HDR_LEN_W-1:0] ext_pos;
  logic                 second_ts;
  logic [HDR_LEN_W-1:0] ts_pos;
  logic [3:0]           ts_code;

  assign advance   = !hdr_valid_r || hdr.ready;
  assign is_last   = (idx == head_data.hdr_len - HDR_LEN_W'(1));
  assign pop       = advance && head_valid && is_last;

  assign ext_start = head_data.hdr_len - EXT_BYTES;
  assign ext_pos   = idx - ext_start;
  assign second_ts = (idx >= POS_TS2);
  assign ts_pos    = second_ts ? idx - POS_TS2 : idx - POS_TS1;

  always_comb begin
    if (second_ts) begin
      ts_code = TS_CODE_DTS;
    end else if (head_data.ts_both) begin
      ts_code = TS_CODE_PTS;
    end else begin
      ts_code = TS_CODE_PTS_ONLY;
    end
  end

  always_comb begin
    case (idx)
      POS_PREFIX2: cur_byte = 8'h01;
      POS_SID:     cur_byte = head_data.sid;
      POS_LEN_HI:  cur_byte = head_data.pkt_len[15:8];
      POS_LEN_LO:  cur_byte = head_data.pkt_len[7:0];
      POS_FLAG1:   cur_byte = head_data.flag1;
      POS_FLAG2:   cur_byte = head_data.flag2;
      POS_HDLEN:   cur_byte = BYTE_W'(head_data.hdr_len - FIXED_HDR_LEN);
      default: begin
        if (idx < POS_PREFIX2) begin
          cur_byte = '0;
        end else if (head_data.ext_on && idx >= ext_start) begin
          case (ext_pos[1:0])
            2'd0:    cur_byte = EXT_BYTE0;
            2'd1:    cur_byte = EXT_BYTE1;
            default: cur_byte = EXT_MARK | {1'b0, head_data.sid_ext};
          endcase
        end else begin
          cur_byte = ts_byte(ts_code, second_ts ? head_data.dts : head_data.pts,
                             ts_pos[2:0]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      hdr_valid_r <= 1'b0;
    end else if (advance) begin
      hdr_valid_r <= head_valid;
      if (head_valid) begin
        idx <= is_last ? '0 : idx + HDR_LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      hdr_byte_r <= cur_byte;
      hdr_last_r <= is_last;
    end
  end

  assign hdr.valid       = hdr_valid_r;
  assign hdr.header_byte = hdr_byte_r;
  assign hdr.last_byte   = hdr_last_r;

endmodule

@@ hw/rtl/pes_header_writer.sv @@
// Channel   Dir  Beat
// req       in   one header request: payload_length, pts/dts present + value
// hdr       out  one header byte, last_byte on the final one
// cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// One header byte per cycle while hdr is ready, via the back-end output register:
// a header is 6 to 22 bytes (6 short, 9 + 5 per timestamp + 3 with extension).
// Requests are classified on accept and held in a QueueDepth-entry queue, so
// req stays ready while a previous header is still going out.
// Reset restores the register defaults, empties the queue and drops hdr.valid.
// A stall on hdr holds the current byte; requests stall only when the queue fills.
module pes_header_writer import phw_pkg::*; #(
  parameter int QueueDepth = PHW_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  phw_req_if.sink                req,
  phw_hdr_if.source              hdr
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic            push;
  phw_desc_t       push_data;
  logic            pop;
  phw_desc_t       head_data;
  logic            head_valid;
  logic            q_full;
  logic [CntW-1:0] q_count;

  phw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  phw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_data  (head_data),
    .head_valid (head_valid),
    .full       (q_full),
    .count      (q_count)
  );

  phw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .hdr        (hdr)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_count <= CntW'(QueueDepth))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> q_count == $past(q_count) + CntW'(1))
    else $error("queue count did not follow push");

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    pop |=> hdr.valid && hdr.last_byte)
    else $error("queue pop without a last byte");

endmodule
